FILE: rtl/core/texel_format_to_rgba8_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXEL_FORMAT_TO_RGBA8_ASSERT_SVH
`define TEXEL_FORMAT_TO_RGBA8_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define TXFMT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define TXFMT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/txfmt_pkg.sv
// ----------------------------------------------------------------------------
// Texel format package
// Format codes, register map, result type and channel widening helpers.
// ----------------------------------------------------------------------------
package txfmt_pkg;

	localparam int unsigned ADDR_W = 3;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned FMT_W  = 4;

	localparam logic REG_PIXEL_FORMAT = 1'b0;

	typedef enum logic [FMT_W-1:0] {
		FMT_RGB555   = 4'd0,
		FMT_A4L4_LO  = 4'd1,
		FMT_L4A4_LO  = 4'd2,
		FMT_A4L4_HI  = 4'd3,
		FMT_L4A4_HI  = 4'd4,
		FMT_L8_LO    = 4'd5,
		FMT_L8_HI    = 4'd6,
		FMT_RGBA4444 = 4'd7,
		FMT_L4_LO_LO = 4'd8,
		FMT_L4_LO_HI = 4'd9,
		FMT_L4_HI_LO = 4'd10,
		FMT_L4_HI_HI = 4'd11
	} fmt_t;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
	localparam logic [7:0] CHAN_FULL    = 8'hFF;
	localparam logic [7:0] CHAN_ZERO    = 8'h00;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	// floor(v * 255 / 31)
	localparam logic [7:0] WIDEN5_LUT [32] = '{
		8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
		8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
		8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
		8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
	};

	// n * 17
	function automatic logic [7:0] widen4(input logic [3:0] n);
		return {n, n};
	endfunction

	function automatic logic [7:0] alpha_key(input logic [7:0] grey);
		return (grey == CHAN_FULL) ? ALPHA_CLEAR : ALPHA_OPAQUE;
	endfunction

endpackage

FILE: rtl/core/txfmt_if.sv
// ----------------------------------------------------------------------------
// Texel channel interfaces
// Valid/ready channels for source texel words and converted RGBA8 texels.
// ----------------------------------------------------------------------------
interface txfmt_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] texel_word;

	modport source (output valid, output texel_word, input ready);
	modport sink   (input valid, input texel_word, output ready);
endinterface

interface txfmt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;

	modport source (output valid, output red, output green, output blue, output alpha,
		input ready);
	modport sink   (input valid, input red, input green, input blue, input alpha,
		output ready);
endinterface

FILE: rtl/core/txfmt_convert.sv
// ----------------------------------------------------------------------------
// Texel converter
// Combinational decode of one 16-bit texel word into RGBA8 by format code.
// ----------------------------------------------------------------------------
module txfmt_convert (
	input  logic [txfmt_pkg::FMT_W-1:0] fmt,
	input  logic [15:0]                 word,
	output txfmt_pkg::rgba_t            rgba
);

	logic [7:0] lo;
	logic [7:0] hi;
	logic [7:0] grey;

	assign lo = word[7:0];
	assign hi = word[15:8];

	always_comb begin
		grey = txfmt_pkg::CHAN_ZERO;
		rgba = '{red: txfmt_pkg::CHAN_FULL, green: txfmt_pkg::CHAN_ZERO,
			blue: txfmt_pkg::CHAN_ZERO, alpha: txfmt_pkg::ALPHA_OPAQUE};
		case (txfmt_pkg::fmt_t'(fmt))
			txfmt_pkg::FMT_RGB555: begin
				rgba.red   = txfmt_pkg::WIDEN5_LUT[word[14:10]];
				rgba.green = txfmt_pkg::WIDEN5_LUT[word[9:5]];
				rgba.blue  = txfmt_pkg::WIDEN5_LUT[word[4:0]];
				rgba.alpha = word[15] ? txfmt_pkg::ALPHA_CLEAR : txfmt_pkg::ALPHA_OPAQUE;
			end
			txfmt_pkg::FMT_A4L4_LO: begin
				grey       = txfmt_pkg::widen4(lo[3:0]);
				rgba       = '{grey, grey, grey, txfmt_pkg::widen4(lo[7:4])};
			end
			txfmt_pkg::FMT_L4A4_LO: begin
				grey       = txfmt_pkg::widen4(lo[7:4]);
				rgba       = '{grey, grey, grey, txfmt_pkg::widen4(lo[3:0])};
			end
			txfmt_pkg::FMT_A4L4_HI: begin
				grey       = txfmt_pkg::widen4(hi[3:0]);
				rgba       = '{grey, grey, grey, txfmt_pkg::widen4(hi[7:4])};
			end
			txfmt_pkg::FMT_L4A4_HI: begin
				grey       = txfmt_pkg::widen4(hi[7:4]);
				rgba       = '{grey, grey, grey, txfmt_pkg::widen4(hi[3:0])};
			end
			txfmt_pkg::FMT_L8_LO: begin
				grey       = lo;
				rgba       = '{grey, grey, grey, txfmt_pkg::alpha_key(grey)};
			end
			txfmt_pkg::FMT_L8_HI: begin
				grey       = hi;
				rgba       = '{grey, grey, grey, txfmt_pkg::alpha_key(grey)};
			end
			txfmt_pkg::FMT_RGBA4444: begin
				rgba = '{txfmt_pkg::widen4(word[15:12]), txfmt_pkg::widen4(word[11:8]),
					txfmt_pkg::widen4(word[7:4]), txfmt_pkg::widen4(word[3:0])};
			end
			txfmt_pkg::FMT_L4_LO_LO: begin
				grey       = txfmt_pkg::widen4(lo[3:0]);
				rgba       = '{grey, grey, grey, txfmt_pkg::alpha_key(grey)};
			end
			txfmt_pkg::FMT_L4_LO_HI: begin
				grey       = txfmt_pkg::widen4(lo[7:4]);
				rgba       = '{grey, grey, grey, txfmt_pkg::alpha_key(grey)};
			end
			txfmt_pkg::FMT_L4_HI_LO: begin
				grey       = txfmt_pkg::widen4(hi[3:0]);
				rgba       = '{grey, grey, grey, txfmt_pkg::alpha_key(grey)};
			end
			txfmt_pkg::FMT_L4_HI_HI: begin
				grey       = txfmt_pkg::widen4(hi[7:4]);
				rgba       = '{grey, grey, grey, txfmt_pkg::alpha_key(grey)};
			end
			default: begin
				// unused codes: opaque debug red
				grey = txfmt_pkg::CHAN_ZERO;
				rgba = '{txfmt_pkg::CHAN_FULL, txfmt_pkg::CHAN_ZERO,
					txfmt_pkg::CHAN_ZERO, txfmt_pkg::ALPHA_OPAQUE};
			end
		endcase
	end

endmodule

FILE: rtl/core/texel_format_to_rgba8.sv
// ----------------------------------------------------------------------------
// Texel format to RGBA8 converter
// Streams 16-bit texel words in and RGBA8 texels out, one beat per cycle while out_ch is ready.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one texel_word per beat; out_ch carries red, green, blue
//   and alpha, exactly one result beat per input beat, in order.
//   The APB port holds one register, pixel_format, at byte address 0;
//   change it only while no beats are in flight.
// Path: an accepted beat is held in the input register, passes the format
//   decode, and is offered from the result register.
// Throughput: one texel per cycle while out_ch.ready stays high, set by the
//   two-stage valid/ready pipeline with no iterative logic.
// Reset: both stages empty, pixel_format returns to RGB555 (code 0).
// Stall: when out_ch.ready is low the result register holds its beat; the
//   input register still fills, so in_ch.ready drops only once both
//   stages are full, and rises again as soon as a result beat leaves.
// ----------------------------------------------------------------------------
`include "texel_format_to_rgba8_assert.svh"

module texel_format_to_rgba8 (
	input  logic                           clk,
	input  logic                           arst_n,
	txfmt_in_if.sink                       in_ch,
	txfmt_out_if.source                    out_ch,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [txfmt_pkg::ADDR_W-1:0]   paddr,
	input  logic [txfmt_pkg::DATA_W-1:0]   pwdata,
	output logic [txfmt_pkg::DATA_W-1:0]   prdata,
	output logic                           pready
);

	logic [txfmt_pkg::FMT_W-1:0] pixel_format_q;
	logic                        cfg_wr;
	logic                        reg_sel;

	logic                        valid_s1;
	logic [15:0]                 word_s1;
	logic                        valid_s2;
	txfmt_pkg::rgba_t            rgba_s2;
	txfmt_pkg::rgba_t            rgba_conv;

	logic                        adv_s2;
	logic                        move_s1;
	logic                        take_in;

	// configuration
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == txfmt_pkg::REG_PIXEL_FORMAT);
	assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
	assign prdata  = reg_sel ?
		{{(txfmt_pkg::DATA_W-txfmt_pkg::FMT_W){1'b0}}, pixel_format_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_format_q <= txfmt_pkg::FMT_RGB555;
		end else if (cfg_wr) begin
			pixel_format_q <= pwdata[txfmt_pkg::FMT_W-1:0];
		end
	end

	// pipeline control
	assign adv_s2      = !valid_s2 || out_ch.ready;
	assign move_s1     = valid_s1 && adv_s2;
	assign in_ch.ready = !valid_s1 || adv_s2;
	assign take_in     = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			word_s1 <= in_ch.texel_word;
		end
		if (move_s1) begin
			rgba_s2 <= rgba_conv;
		end
	end

	txfmt_convert u_convert (
		.fmt  (pixel_format_q),
		.word (word_s1),
		.rgba (rgba_conv)
	);

	assign out_ch.valid = valid_s2;
	assign out_ch.red   = rgba_s2.red;
	assign out_ch.green = rgba_s2.green;
	assign out_ch.blue  = rgba_s2.blue;
	assign out_ch.alpha = rgba_s2.alpha;

	`TXFMT_ASSERT_NEXT(a_in_lands, take_in, valid_s1, "accepted beat not held in input stage")
	`TXFMT_ASSERT_NEXT(a_s1_moves, move_s1, valid_s2, "input stage beat lost on advance")
	`TXFMT_ASSERT_NEXT(a_debug_red, move_s1 && (pixel_format_q > txfmt_pkg::FMT_L4_HI_HI),
		(rgba_s2.red == 8'hFF) && (rgba_s2.green == 8'h00) && (rgba_s2.blue == 8'h00)
		&& (rgba_s2.alpha == 8'hFF), "unused format did not give opaque red")
	`TXFMT_ASSERT_NEXT(a_grey_fmt, move_s1 && (pixel_format_q >= txfmt_pkg::FMT_A4L4_LO)
		&& (pixel_format_q <= txfmt_pkg::FMT_L8_HI), (rgba_s2.red == rgba_s2.green)
		&& (rgba_s2.green == rgba_s2.blue), "grey format gave unequal colour channels")

endmodule
